// ----- rtl/lz77te_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lz77te_pkg;

  // Each node of the nearest-candidate tree merges 2**SCAN_RADIX_LOG2 children.
  localparam int SCAN_RADIX_LOG2 = 3;

  // Per-item controls broadcast to every window cell.
  typedef struct packed {
    logic shift;      // An item was accepted: compare, then move the window by one.
    logic start;      // The item opens a token, so any filled cell may start a match.
    logic last;       // The item ends the stream, so the window empties.
    logic clear_tok;  // The token just closed; no cell belongs to the current token.
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lz77te_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lz77te_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  lz77te_pkg::cell_ctl_t ctl,
  input  wire  [7:0]            din,
  input  wire  [7:0]            prev_byte,
  input  wire                   prev_filled,
  input  wire                   prev_token,
  output logic [7:0]            hist_byte,
  output logic                  filled,
  output logic                  in_token,
  output logic                  alive
);
  import lz77te_pkg::*;

  logic ok;

  // A cell sits at a fixed distance from the newest byte, so a match that
  // started this far back keeps comparing against this same cell.
  always_comb begin
    ok = (hist_byte == din) && (ctl.start ? filled : (alive && !in_token));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled   <= 1'b0;
      in_token <= 1'b0;
      alive    <= 1'b0;
    end else if (ctl.shift) begin
      filled   <= prev_filled && !ctl.last;
      in_token <= prev_token;
      alive    <= ok && !ctl.last;
    end else if (ctl.clear_tok) begin
      in_token <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hist_byte <= prev_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lz77te_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lz77te_scan #(
  parameter int WINDOW_SIZE = 1024,
  parameter int LEVELS      = 4
) (
  input  wire                                             clk,
  input  wire                                             rst,
  input  wire  [WINDOW_SIZE-1:0]                          alive,
  output logic                                            found,
  output logic [lz77te_pkg::SCAN_RADIX_LOG2*LEVELS-1:0]   first_idx
);
  import lz77te_pkg::*;

  localparam int RADIX  = 1 << SCAN_RADIX_LOG2;
  localparam int IW     = SCAN_RADIX_LOG2 * LEVELS;
  localparam int LEAVES = 1 << IW;

  // Position of the first node of a tree level in the flat node arrays.
  function automatic int node_base(input int level);
    int sum;
    sum = 0;
    for (int m = 1; m < level; m++) begin
      sum += LEAVES >> (SCAN_RADIX_LOG2 * m);
    end
    return sum;
  endfunction

  localparam int NODES = node_base(LEVELS + 1);
  localparam int ROOT  = node_base(LEVELS);

  function automatic logic [IW-1:0] first_of(input logic [RADIX-1:0] f,
                                             input logic [RADIX-1:0][IW-1:0] ix);
    logic [IW-1:0] r;
    r = '0;
    for (int c = RADIX - 1; c >= 0; c--) begin
      if (f[c]) begin
        r = ix[c];
      end
    end
    return r;
  endfunction

  wire  [NODES-1:0] fnd_d;
  wire  [IW-1:0]    idx_d [NODES];
  logic [NODES-1:0] fnd_q;
  logic [IW-1:0]    idx_q [NODES];

  // Each node keeps the lowest set cell index below it; every tree level is registered.
  for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
    for (genvar n = 0; n < (LEAVES >> (SCAN_RADIX_LOG2 * k)); n++) begin : g_node
      wire [RADIX-1:0]         cf;
      wire [RADIX-1:0][IW-1:0] cix;
      for (genvar c = 0; c < RADIX; c++) begin : g_child
        if (k == 1) begin : g_leaf
          if (RADIX * n + c < WINDOW_SIZE) begin : g_real
            assign cf[c] = alive[RADIX * n + c];
          end else begin : g_pad
            assign cf[c] = 1'b0;
          end
          assign cix[c] = IW'(RADIX * n + c);
        end else begin : g_inner
          assign cf[c]  = fnd_q[node_base(k - 1) + RADIX * n + c];
          assign cix[c] = idx_q[node_base(k - 1) + RADIX * n + c];
        end
      end
      assign fnd_d[node_base(k) + n] = |cf;
      assign idx_d[node_base(k) + n] = first_of(cf, cix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fnd_q <= '0;
    end else begin
      fnd_q <= fnd_d;
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= idx_d;
  end

  assign found     = fnd_q[ROOT];
  assign first_idx = idx_q[ROOT];

endmodule

`default_nettype wire

// ----- rtl/lz77_triple_encoder.sv -----
// LZ77 triple encoder. Raw bytes enter on the input channel (data_byte with
// is_last marking the final byte of a stream) under in_valid/in_ready. Tokens
// leave on the output channel as (match_offset, match_length, next_literal,
// end_of_stream) under out_valid/out_ready; a byte that extends a match gives
// no token. The history is a row of WINDOW_SIZE cells that shifts by one byte
// per accepted item; every cell compares its byte with the incoming one, so
// all window positions are tried at once.
// Each byte passes through a compare-and-shift step, then the registered 8-way
// tree of LEVELS = ceil(log2(WINDOW_SIZE) / 3) levels that finds whether any
// match survives and which one is nearest, then a step that closes or extends
// the token; the next byte is taken only after that. A token appears on the
// output in the cycle after its last byte is resolved.
// While a token waits on a stalled receiver, the next byte is still taken; a
// byte that must close a further token then waits until the output register
// frees. After reset, and after each byte with is_last set, the window is empty
// and the next byte starts a new stream.
`timescale 1ns / 1ps
`default_nettype none

module lz77_triple_encoder #(
  parameter int WINDOW_SIZE = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [7:0]                          data_byte,
  input  wire                                 is_last,
  input  wire                                 in_valid,
  output logic                                in_ready,
  output logic [$clog2(WINDOW_SIZE + 1)-1:0]  match_offset,
  output logic [$clog2(WINDOW_SIZE + 1)-1:0]  match_length,
  output logic [7:0]                          next_literal,
  output logic                                end_of_stream,
  output logic                                out_valid,
  input  wire                                 out_ready
);
  import lz77te_pkg::*;

  localparam int OW          = $clog2(WINDOW_SIZE + 1);
  localparam int SCAN_LEVELS = ($clog2(WINDOW_SIZE) + SCAN_RADIX_LOG2 - 1) / SCAN_RADIX_LOG2;
  localparam int IW          = SCAN_RADIX_LOG2 * SCAN_LEVELS;
  localparam int CW          = $clog2(SCAN_LEVELS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   scan_cnt;
  logic [OW-1:0]   match_len;
  logic [OW-1:0]   best_dist;
  logic [7:0]      lit;
  logic            last_item;

  cell_ctl_t       cell_ctl;
  logic            accept;
  logic            cont;
  logic            out_free;
  logic            end_tok;
  logic            found;
  logic [IW-1:0]   first_idx;

  wire  [7:0]             chain_byte [WINDOW_SIZE + 1];
  wire  [WINDOW_SIZE:0]   chain_filled;
  wire  [WINDOW_SIZE:0]   chain_tok;
  wire  [WINDOW_SIZE-1:0] alive_vec;

  // The newest byte enters the row as filled and as part of the current token.
  assign chain_byte[0]   = data_byte;
  assign chain_filled[0] = 1'b1;
  assign chain_tok[0]    = 1'b1;

  for (genvar j = 0; j < WINDOW_SIZE; j++) begin : g_cell
    lz77te_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .din         (data_byte),
      .prev_byte   (chain_byte[j]),
      .prev_filled (chain_filled[j]),
      .prev_token  (chain_tok[j]),
      .hist_byte   (chain_byte[j + 1]),
      .filled      (chain_filled[j + 1]),
      .in_token    (chain_tok[j + 1]),
      .alive       (alive_vec[j])
    );
  end

  lz77te_scan #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .LEVELS      (SCAN_LEVELS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .alive     (alive_vec),
    .found     (found),
    .first_idx (first_idx)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cont     = found && !last_item;
  assign out_free = !out_valid || out_ready;
  assign end_tok  = (state == S_DONE) && !cont && out_free;

  always_comb begin
    cell_ctl.shift     = accept;
    cell_ctl.start     = (match_len == '0);
    cell_ctl.last      = is_last;
    cell_ctl.clear_tok = end_tok;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == CW'(SCAN_LEVELS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (cont || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      match_len <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_cnt <= '0;
      end else if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if ((state == S_DONE) && cont) begin
        match_len <= match_len + 1'b1;
      end else if (end_tok) begin
        match_len <= '0;
      end
      if (end_tok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lit       <= data_byte;
      last_item <= is_last;
    end
    // Cell j holds the byte j + 1 positions back, so the lowest surviving
    // cell is the nearest match start.
    if ((state == S_DONE) && cont) begin
      best_dist <= OW'(first_idx) + 1'b1;
    end
    if (end_tok) begin
      match_offset  <= (match_len == '0) ? '0 : best_dist;
      match_length  <= match_len;
      next_literal  <= lit;
      end_of_stream <= last_item;
    end
  end

endmodule

`default_nettype wire
